// ===== hdl/dfr_pkg.sv =====
// Shared types and constants of the length-prefix and line deframer.
`default_nettype none
package dfr_pkg;

    // Field widths
    localparam int BYTE_W        = 8;
    localparam int KIND_W        = 2;
    localparam int FRAME_LIMIT_W = 15;
    localparam int LINE_LIMIT_W  = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;
    localparam int LEN_W         = 32;
    localparam int HDR_CNT_W     = 3;

    // Hard ceilings on the programmable limits
    localparam logic [FRAME_LIMIT_W-1:0] FRAME_MAX = 15'd16384;
    localparam logic [LINE_LIMIT_W-1:0]  LINE_MAX  = 13'd4096;

    // Header is four bytes, most significant first
    localparam logic [HDR_CNT_W-1:0] HDR_BYTES = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 2'd2;

    // Mode values
    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_LINE  = 1'b1;

    // Characters
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KIND_W-1:0] kind;
        logic              last;
    } res_t;

    // Up to two results per input byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage
`default_nettype wire

// ===== hdl/dfr_engine.sv =====
// Stream state, configuration registers and the per-byte decode logic.
`default_nettype none
module dfr_engine (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [dfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [dfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 advance,
    input  wire  [dfr_pkg::BYTE_W-1:0]          rx_byte,
    input  wire                                 restart,
    output dfr_pkg::push_t                      push
);
    import dfr_pkg::*;

    logic                     mode_reg;
    logic [FRAME_LIMIT_W-1:0] frame_limit_reg;
    logic [LINE_LIMIT_W-1:0]  line_limit_reg;

    logic                     failed_reg,       failed_next;
    logic [HDR_CNT_W-1:0]     header_count_reg, header_count_next;
    logic [LEN_W-1:0]         length_acc_reg,   length_acc_next;
    logic [FRAME_LIMIT_W-1:0] payload_left_reg, payload_left_next;
    logic [LINE_LIMIT_W-1:0]  line_count_reg,   line_count_next;
    logic                     cr_held_reg,      cr_held_next;

    logic [FRAME_LIMIT_W-1:0] frame_lim;
    logic [LINE_LIMIT_W-1:0]  line_lim;
    logic [LEN_W-1:0]         acc;
    logic [HDR_CNT_W-1:0]     hdr_cnt;
    logic [FRAME_LIMIT_W-1:0] left_dec;
    logic [LINE_LIMIT_W-1:0]  line_inc;

    assign frame_lim = (frame_limit_reg > FRAME_MAX) ? FRAME_MAX : frame_limit_reg;
    assign line_lim  = (line_limit_reg > LINE_MAX) ? LINE_MAX : line_limit_reg;
    assign acc       = {length_acc_reg[LEN_W-BYTE_W-1:0], rx_byte};
    assign hdr_cnt   = header_count_reg + 3'd1;
    assign left_dec  = payload_left_reg - 15'd1;
    assign line_inc  = line_count_reg + 13'd1;

    always_comb
    begin
        failed_next       = failed_reg;
        header_count_next = header_count_reg;
        length_acc_next   = length_acc_reg;
        payload_left_next = payload_left_reg;
        line_count_next   = line_count_reg;
        cr_held_next      = cr_held_reg;
        push              = '0;

        if (restart)
        begin
            failed_next       = 1'b0;
            header_count_next = '0;
            length_acc_next   = '0;
            payload_left_next = '0;
            line_count_next   = '0;
            cr_held_next      = 1'b0;
        end
        else if (failed_reg)
        begin
            push.count   = 2'd1;
            push.r0.kind = KIND_ERR;
        end
        else if (mode_reg == MODE_FRAME)
        begin
            if (payload_left_reg != '0)
            begin
                payload_left_next = left_dec;
                push.count        = 2'd1;
                push.r0.out_byte  = rx_byte;
                push.r0.kind      = KIND_DATA;
                push.r0.last      = (left_dec == '0);
            end
            else
            begin
                length_acc_next   = acc;
                header_count_next = hdr_cnt;
                if (hdr_cnt >= HDR_BYTES)
                begin
                    if ((acc == '0) || (acc > {{(LEN_W-FRAME_LIMIT_W){1'b0}}, frame_lim}))
                    begin
                        // Illegal length: fail and hold the header as it stands
                        failed_next  = 1'b1;
                        push.count   = 2'd1;
                        push.r0.kind = KIND_ERR;
                    end
                    else
                    begin
                        payload_left_next = acc[FRAME_LIMIT_W-1:0];
                        header_count_next = '0;
                        length_acc_next   = '0;
                    end
                end
            end
        end
        else
        begin
            if (rx_byte == CHAR_LF)
            begin
                // Held CR is dropped with the line end
                cr_held_next    = 1'b0;
                line_count_next = '0;
                push.count      = 2'd1;
                push.r0.kind    = KIND_EOL;
            end
            else
            begin
                line_count_next = line_inc;
                if (line_inc >= line_lim)
                begin
                    failed_next  = 1'b1;
                    cr_held_next = 1'b0;
                    push.count   = 2'd1;
                    push.r0.kind = KIND_ERR;
                end
                else
                begin
                    cr_held_next = (rx_byte == CHAR_CR);
                    if (cr_held_reg)
                    begin
                        // Release the older CR ahead of this byte
                        push.r0.out_byte = CHAR_CR;
                        push.r0.kind     = KIND_DATA;
                        if (rx_byte == CHAR_CR)
                        begin
                            push.count = 2'd1;
                        end
                        else
                        begin
                            push.count       = 2'd2;
                            push.r1.out_byte = rx_byte;
                            push.r1.kind     = KIND_DATA;
                        end
                    end
                    else if (rx_byte != CHAR_CR)
                    begin
                        push.count       = 2'd1;
                        push.r0.out_byte = rx_byte;
                        push.r0.kind     = KIND_DATA;
                    end
                end
            end
        end

        if (!advance)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_FRAME;
            frame_limit_reg <= 15'd16384;
            line_limit_reg  <= 13'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[0];
                REG_FRAME_LIMIT: frame_limit_reg <= cfg_data[FRAME_LIMIT_W-1:0];
                REG_LINE_LIMIT:  line_limit_reg  <= cfg_data[LINE_LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg       <= 1'b0;
            header_count_reg <= '0;
            length_acc_reg   <= '0;
            payload_left_reg <= '0;
            line_count_reg   <= '0;
            cr_held_reg      <= 1'b0;
        end
        else if (advance)
        begin
            failed_reg       <= failed_next;
            header_count_reg <= header_count_next;
            length_acc_reg   <= length_acc_next;
            payload_left_reg <= payload_left_next;
            line_count_reg   <= line_count_next;
            cr_held_reg      <= cr_held_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/dfr_out_queue.sv =====
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module dfr_out_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  dfr_pkg::push_t               push,
    output logic                         room,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output dfr_pkg::res_t                head
);
    import dfr_pkg::*;

    res_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg,  count_next;
    logic               pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];
    // Accept only with space for the worst case of two results
    assign room     = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + Q_PTR_W'(1)] <= push.r1;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/length_prefix_and_line_deframer_core.sv =====
// Top level of the length-prefix and line deframer.
//
//  Channel   Direction  Transaction                    Fields (low bit first)
//  s_axis    in         one received byte              tdata: rx_byte, tuser: restart
//  m_axis    out        one result                     tdata: out_byte, tuser: kind,
//                                                      tlast: last
//  cfg       in         one register write, no wait    index 0 mode, 1 frame_limit,
//                                                      2 line_limit
//
// One byte is taken per cycle while s_tready is high. A byte waits in the input
// register until the queue has room, is decoded there, and its results (none, one
// or two) land in a four-entry queue; a result reaches m_tvalid only after passing
// the input register and the queue. The queue read port sets the output rate at
// one result per cycle while m_tready is high; a byte that releases a held CR
// produces two results. s_tready drops only while the input register holds a byte
// and the queue has fewer than two free entries. Reset clears the stream state,
// restores the register defaults and empties the queue.
`default_nettype none
module length_prefix_and_line_deframer_core (
    input  wire                               clk,
    input  wire                               rst_n,
    // Configuration write port
    input  wire                               cfg_we,
    input  wire  [dfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [dfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Received bytes
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [7:0]                        s_tdata,   // [7:0] rx_byte
    input  wire                               s_tuser,   // [0] restart
    // Results
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    output logic [1:0]                        m_tuser,   // [1:0] kind
    output logic                              m_tlast    // last
);
    import dfr_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_restart_reg;

    logic  advance;
    logic  room;
    push_t push;
    res_t  head;

    // Decode the held byte once the queue can take its worst case
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: load on every transaction, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    dfr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .rx_byte   (in_byte_reg),
        .restart   (in_restart_reg),
        .push      (push)
    );

    dfr_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
`default_nettype wire

// ===== hdl/dfr_checker.sv =====
// Port-level checks of the deframer and their binding to the top level.
`default_nettype none
module dfr_checker (
    input  wire       clk,
    input  wire       rst_n,
    input  wire       s_tready,
    input  wire       m_tvalid,
    input  wire       m_tready,
    input  wire [7:0] m_tdata,
    input  wire [1:0] m_tuser,
    input  wire       m_tlast
);
    import dfr_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Input back-pressure only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // Markers carry a zero byte and never close a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_DATA) |-> (m_tdata == 8'd0) && !m_tlast)
        else $error("marker with data or last");

    // Nothing is offered straight out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind length_prefix_and_line_deframer_core dfr_checker u_dfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
